>>> hw/rtl/mstt_pkg.sv
// ----------------------------------------------------------------------------
// mstt_pkg: shared types and constants of the multi-screen text terminal
// Holds the decoded work-item layout, configuration bundle and fixed codes.
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] DIGIT_ATTR = 8'h04;

    localparam logic [7:0]  RST_TEXT_COLOR   = 8'd15;
    localparam logic [7:0]  RST_PROMPT_COLOR = 8'd10;
    localparam logic [7:0]  RST_BLANK_COLOR  = 8'd7;
    localparam logic [39:0] RST_PROMPT_TEXT  = 40'h203E73666B;

    localparam int unsigned PROMPT_LEN = 5;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_SELECT = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [7:0] REG_TEXT_COLOR   = 8'd0;
    localparam logic [7:0] REG_PROMPT_COLOR = 8'd1;
    localparam logic [7:0] REG_BLANK_COLOR  = 8'd2;
    localparam logic [7:0] REG_PROMPT_TEXT  = 8'd3;

    typedef enum logic [2:0] {
        K_PUTC,
        K_NEWLINE,
        K_SELECT,
        K_READ,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  char_code;
        logic [2:0]  screen_index;
        logic [10:0] cell_index;
    } item_t;

    typedef struct packed {
        logic [7:0]  text_color;
        logic [7:0]  prompt_color;
        logic [7:0]  blank_color;
        logic [39:0] prompt_text;
    } cfg_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

>>> hw/rtl/mstt_ram.sv
// ----------------------------------------------------------------------------
// mstt_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mstt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/mstt_front.sv
// ----------------------------------------------------------------------------
// mstt_front: command intake and classification
// Decode each accepted word into a work item and hold it in a two-entry queue.
// ----------------------------------------------------------------------------
module mstt_front #(
    parameter int SCREENS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            op,
    input  logic [7:0]            char_code,
    input  logic [2:0]            screen_index,
    input  logic [10:0]           cell_index,
    input  mstt_pkg::back_status_t status,
    output logic                  q_valid,
    output mstt_pkg::item_t       q_item,
    input  logic                  q_pop
);

    mstt_pkg::item_t q_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    mstt_pkg::item_t dec;
    logic            push;

    always_comb
    begin
        dec.char_code    = char_code;
        dec.screen_index = screen_index;
        dec.cell_index   = cell_index;
        case (op)
            mstt_pkg::OP_PUT:
                dec.kind = (char_code == mstt_pkg::CH_NEWLINE) ? mstt_pkg::K_NEWLINE
                                                               : mstt_pkg::K_PUTC;
            mstt_pkg::OP_SELECT:
                dec.kind = ({29'd0, screen_index} < SCREENS) ? mstt_pkg::K_SELECT
                                                            : mstt_pkg::K_NOP;
            mstt_pkg::OP_READ:
                dec.kind = mstt_pkg::K_READ;
            default:
                dec.kind = mstt_pkg::K_NOP;
        endcase
    end

    assign busy    = (count_reg == 2'd2) || status.clearing;
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

>>> hw/rtl/mstt_back.sv
// ----------------------------------------------------------------------------
// mstt_back: command execution engine
// Carry out work items against the cell RAM: writes, scrolls, prompts, reads.
// ----------------------------------------------------------------------------
module mstt_back #(
    parameter int SCREENS = 4,
    parameter int COLS    = 80,
    parameter int ROWS    = 25
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  mstt_pkg::item_t        q_item,
    output logic                   q_pop,
    input  mstt_pkg::cfg_t         cfg,
    output mstt_pkg::back_status_t status,
    output logic                   done,
    output logic [1:0]             active_screen,
    output logic [10:0]            cursor_position,
    output logic [15:0]            read_cell,
    output logic                   scrolled
);

    localparam int CELLS = ROWS * COLS;
    localparam int TOTAL = SCREENS * CELLS;
    localparam int AW    = $clog2(TOTAL);
    localparam int OW    = $clog2(CELLS);
    localparam int SW    = (SCREENS > 1) ? $clog2(SCREENS) : 1;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int NW    = $clog2(TOTAL + 1);
    localparam int PROMPT_LEN_C = mstt_pkg::PROMPT_LEN;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_BLANK,
        S_PROMPT
    } state_t;

    state_t          state_reg, state_next;
    logic [SW-1:0]   sel_reg, sel_next;
    logic [RW-1:0]   row_reg [SCREENS];
    logic [RW-1:0]   row_next [SCREENS];
    logic [CW-1:0]   col_reg [SCREENS];
    logic [CW-1:0]   col_next [SCREENS];
    logic [NW-1:0]   cnt_reg, cnt_next;
    logic            pend_reg, pend_next;
    logic            nl_reg, nl_next;
    logic            scr_reg, scr_next;
    logic            done_reg, done_next;
    logic [15:0]     rcell_reg, rcell_next;
    logic            scrolled_reg, scrolled_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [15:0]     mem_wdata, mem_rdata;

    logic [AW-1:0]   base;
    logic [RW-1:0]   cur_row;
    logic [CW-1:0]   cur_col;
    logic [AW-1:0]   row_off;
    logic [11:0]     cidx;
    logic [2:0]      pidx;
    logic [OW-1:0]   pos;

    mstt_ram #(
        .WIDTH (16),
        .DEPTH (TOTAL)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign base    = AW'(sel_reg) * AW'(CELLS);
    assign cur_row = row_reg[sel_reg];
    assign cur_col = col_reg[sel_reg];
    assign row_off = AW'(cur_row) * AW'(COLS);
    assign cidx    = {1'b0, q_item.cell_index};
    assign pidx    = cnt_reg[2:0];
    assign pos     = OW'(cur_row) * OW'(COLS) + OW'(cur_col);

    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        nl_next       = nl_reg;
        scr_next      = scr_reg;
        done_next     = 1'b0;
        rcell_next    = 16'd0;
        scrolled_next = 1'b0;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = base + row_off + AW'(cur_col);
        mem_wdata     = {cfg.text_color, q_item.char_code};
        mem_raddr     = base + AW'(cidx);

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(cnt_reg);
                if (cnt_reg < NW'(PROMPT_LEN_C))
                begin
                    mem_wdata = {mstt_pkg::RST_PROMPT_COLOR,
                                 mstt_pkg::RST_PROMPT_TEXT[pidx*8 +: 8]};
                end
                else
                begin
                    mem_wdata = {mstt_pkg::RST_BLANK_COLOR, mstt_pkg::CH_SPACE};
                end
                cnt_next = cnt_reg + NW'(1);
                if (cnt_reg == NW'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.kind)
                        mstt_pkg::K_PUTC:
                        begin
                            mem_we = 1'b1;
                            if (cur_col == CW'(COLS - 1))
                            begin
                                col_next[sel_reg] = '0;
                                if (cur_row == RW'(ROWS - 1))
                                begin
                                    state_next = S_SCROLL;
                                    cnt_next   = '0;
                                    pend_next  = 1'b0;
                                    nl_next    = 1'b0;
                                end
                                else
                                begin
                                    row_next[sel_reg] = cur_row + RW'(1);
                                    done_next = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next[sel_reg] = cur_col + CW'(1);
                                done_next = 1'b1;
                            end
                        end
                        mstt_pkg::K_NEWLINE:
                        begin
                            col_next[sel_reg] = '0;
                            cnt_next = '0;
                            if (cur_row == RW'(ROWS - 1))
                            begin
                                state_next = S_SCROLL;
                                pend_next  = 1'b0;
                                nl_next    = 1'b1;
                                scr_next   = 1'b1;
                            end
                            else
                            begin
                                row_next[sel_reg] = cur_row + RW'(1);
                                state_next = S_PROMPT;
                                scr_next   = 1'b0;
                            end
                        end
                        mstt_pkg::K_SELECT:
                        begin
                            sel_next  = SW'(q_item.screen_index);
                            done_next = 1'b1;
                        end
                        mstt_pkg::K_READ:
                        begin
                            if (cidx == 12'(COLS - 1))
                            begin
                                rcell_next = {mstt_pkg::DIGIT_ATTR,
                                              mstt_pkg::CH_ZERO + 8'(sel_reg)};
                                done_next  = 1'b1;
                            end
                            else if ({20'd0, cidx} < CELLS)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rcell_next = mem_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                mem_raddr = base + AW'(cnt_reg) + AW'(COLS);
                if (cnt_reg < NW'(CELLS - COLS))
                begin
                    cnt_next  = cnt_reg + NW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = base + AW'(cnt_reg) - AW'(1);
                    mem_wdata = mem_rdata;
                end
                else if (cnt_reg == NW'(CELLS - COLS))
                begin
                    state_next = S_BLANK;
                    cnt_next   = '0;
                end
            end
            S_BLANK:
            begin
                mem_we    = 1'b1;
                mem_waddr = base + AW'((ROWS - 1) * COLS) + AW'(cnt_reg);
                mem_wdata = {cfg.blank_color, mstt_pkg::CH_SPACE};
                cnt_next  = cnt_reg + NW'(1);
                if (cnt_reg == NW'(COLS - 1))
                begin
                    cnt_next = '0;
                    if (nl_reg)
                    begin
                        state_next = S_PROMPT;
                    end
                    else
                    begin
                        state_next    = S_IDLE;
                        done_next     = 1'b1;
                        scrolled_next = 1'b1;
                    end
                end
            end
            S_PROMPT:
            begin
                mem_we    = 1'b1;
                mem_waddr = base + row_off + AW'(cnt_reg);
                mem_wdata = {cfg.prompt_color, cfg.prompt_text[pidx*8 +: 8]};
                cnt_next  = cnt_reg + NW'(1);
                if (cnt_reg == NW'(PROMPT_LEN_C - 1))
                begin
                    col_next[sel_reg] = CW'(PROMPT_LEN_C);
                    state_next    = S_IDLE;
                    done_next     = 1'b1;
                    scrolled_next = scr_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            sel_reg      <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            nl_reg       <= 1'b0;
            scr_reg      <= 1'b0;
            done_reg     <= 1'b0;
            rcell_reg    <= 16'd0;
            scrolled_reg <= 1'b0;
            for (int i = 0; i < SCREENS; i++)
            begin
                row_reg[i] <= '0;
                col_reg[i] <= (i == 0) ? CW'(PROMPT_LEN_C) : '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            sel_reg      <= sel_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            nl_reg       <= nl_next;
            scr_reg      <= scr_next;
            done_reg     <= done_next;
            rcell_reg    <= rcell_next;
            scrolled_reg <= scrolled_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

    assign status.clearing = (state_reg == S_CLEAR);
    assign done            = done_reg;
    assign read_cell       = rcell_reg;
    assign scrolled        = scrolled_reg;
    assign active_screen   = 2'(sel_reg);
    assign cursor_position = 11'(pos);

endmodule

>>> hw/rtl/multi_screen_text_terminal_core.sv
// ----------------------------------------------------------------------------
// multi_screen_text_terminal_core: multi-screen character-cell terminal
// Several text screens in one cell RAM, with per-screen cursors.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op/char_code/screen_index/cell_index with start;
//   the word is taken at a clock edge where start is high and busy is low.
//   A two-word queue sits between intake and execution.
//   Result channel: every command gives one result word, shown for one cycle
//   with done high. The receiver cannot stall; take it when done is high.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Write only while no command is outstanding.
// Execution (command accepted to done), in the execution sequencer:
//   select, non-newline put, out-of-range or top-right read: answered from idle;
//   read of a stored cell: through the read state (registered RAM read);
//   newline without scroll: five prompt writes, one per cycle;
//   wrapping put that scrolls: every row but the top is moved up one row
//   (one cell per cycle through the single RAM write port), then COLS
//   blank writes; a newline that scrolls adds 5 prompt writes.
// Reset: the sequencer sweeps the whole RAM, one cell per cycle, over all
//   SCREENS*ROWS*COLS cells (8000 by default), writing blanks and the
//   screen 0 prompt; busy stays high for that pass.
// ----------------------------------------------------------------------------
module multi_screen_text_terminal_core #(
    parameter int SCREENS = 4,
    parameter int COLS    = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [7:0]  char_code,
    input  logic [2:0]  screen_index,
    input  logic [10:0] cell_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [39:0] cfg_data,
    output logic        done,
    output logic [1:0]  active_screen,
    output logic [10:0] cursor_position,
    output logic [15:0] read_cell,
    output logic        scrolled
);

    mstt_pkg::cfg_t         cfg_reg;
    mstt_pkg::back_status_t status;
    mstt_pkg::item_t        q_item;
    logic                   q_valid;
    logic                   q_pop;

    // Config writes land immediately; no back-pressure on this channel.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.text_color   <= mstt_pkg::RST_TEXT_COLOR;
            cfg_reg.prompt_color <= mstt_pkg::RST_PROMPT_COLOR;
            cfg_reg.blank_color  <= mstt_pkg::RST_BLANK_COLOR;
            cfg_reg.prompt_text  <= mstt_pkg::RST_PROMPT_TEXT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mstt_pkg::REG_TEXT_COLOR:   cfg_reg.text_color   <= cfg_data[7:0];
                mstt_pkg::REG_PROMPT_COLOR: cfg_reg.prompt_color <= cfg_data[7:0];
                mstt_pkg::REG_BLANK_COLOR:  cfg_reg.blank_color  <= cfg_data[7:0];
                mstt_pkg::REG_PROMPT_TEXT:  cfg_reg.prompt_text  <= cfg_data;
                default:                    ; // drop writes to unknown indexes
            endcase
        end
    end

    // Front: take the command word, classify it and queue it.
    mstt_front #(
        .SCREENS (SCREENS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .char_code    (char_code),
        .screen_index (screen_index),
        .cell_index   (cell_index),
        .status       (status),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // Back: execute queued items against the cell RAM and report results.
    mstt_back #(
        .SCREENS (SCREENS),
        .COLS    (COLS),
        .ROWS    (ROWS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .cfg             (cfg_reg),
        .status          (status),
        .done            (done),
        .active_screen   (active_screen),
        .cursor_position (cursor_position),
        .read_cell       (read_cell),
        .scrolled        (scrolled)
    );

`ifndef SYNTH
    // Intake must stay closed while the RAM is being cleared.
    a_busy_when_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> busy)
        else $error("command accepted during clearing pass");

    // The read_cell and scrolled fields are zero outside the done strobe.
    a_quiet_between_results: assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (read_cell == 16'd0) && !scrolled)
        else $error("result payload active without done");

    // The cursor points into the screen (checked when ROWS*COLS fits 11 bits).
    a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (ROWS * COLS > 2048) || ({21'd0, cursor_position} < ROWS * COLS))
        else $error("cursor outside the screen");
`endif

endmodule
